// File: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared types and constants
// Word widths, pipeline depths and the stage payload structs.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int DW         = 16;
  localparam int NUM_W      = DW + 1;
  localparam int RAD_W      = 17;
  localparam int X_W        = 32;
  localparam int ROOT_W     = 16;
  localparam int REM_W      = 17;
  localparam int N_W        = 31;
  localparam int DSH_W      = 32;
  localparam int Q_W        = 16;
  localparam int LANES      = 3;
  localparam int SQ_STAGES  = 8;
  localparam int DIV_STAGES = 8;
  localparam int IN_W       = 9 * DW;
  localparam int OUT_W      = 4 * DW;

  // Which quaternion component is the dominant one (taken from the root).
  localparam logic [1:0] DOM_W = 2'd0;
  localparam logic [1:0] DOM_X = 2'd1;
  localparam logic [1:0] DOM_Y = 2'd2;
  localparam logic [1:0] DOM_Z = 2'd3;

  typedef struct packed {
    logic [X_W-1:0]              x;
    logic [REM_W-1:0]            rem;
    logic [ROOT_W-1:0]           root;
    logic [LANES-1:0][NUM_W-1:0] num;
    logic [1:0]                  dom;
  } sq_t;

  typedef struct packed {
    logic [N_W-1:0]   rem;
    logic [DSH_W-1:0] dsh;
    logic [Q_W-1:0]   q;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [DW-1:0]     dom_val;
    logic [1:0]        dom;
    logic              degen;
  } dv_t;

endpackage

// File: rtl/rmq_prep.sv
// ----------------------------------------------------------------------------
// Front stage
// Trace test, dominant axis choice, radicand and the three numerators.
// ----------------------------------------------------------------------------
module rmq_prep (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  logic [rmq_pkg::IN_W-1:0] in_d,
  output logic                     out_v,
  output rmq_pkg::sq_t             out_d
);
  import rmq_pkg::*;

  logic signed [DW-1:0]    m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [DW+1:0]    trace;
  logic signed [DW+2:0]    rad_s;
  logic signed [DW+2:0]    one_s;
  logic signed [NUM_W-1:0] n0, n1, n2;
  logic [1:0]              dom;
  logic [RAD_W-1:0]        rad;
  logic                    out_v_r;
  sq_t                     out_d_r, out_d_nxt;

  always_comb begin
    m00 = in_d[0*DW +: DW];
    m01 = in_d[1*DW +: DW];
    m02 = in_d[2*DW +: DW];
    m10 = in_d[3*DW +: DW];
    m11 = in_d[4*DW +: DW];
    m12 = in_d[5*DW +: DW];
    m20 = in_d[6*DW +: DW];
    m21 = in_d[7*DW +: DW];
    m22 = in_d[8*DW +: DW];
    one_s = (DW+3)'(1) <<< FRAC_BITS;
    trace = (DW+2)'(m00) + (DW+2)'(m11) + (DW+2)'(m22);
    if (trace > 0) begin
      dom   = DOM_W;
      rad_s = (DW+3)'(trace) + one_s;
      n0    = NUM_W'(m21) - NUM_W'(m12);
      n1    = NUM_W'(m02) - NUM_W'(m20);
      n2    = NUM_W'(m10) - NUM_W'(m01);
    end else if (m22 > m00 && m22 > m11 || m22 > m00 && m11 <= m00) begin
      // Lower index wins ties on the diagonal.
      dom   = DOM_Z;
      rad_s = (DW+3)'(m22) - (DW+3)'(m00) - (DW+3)'(m11) + one_s;
      n0    = NUM_W'(m10) - NUM_W'(m01);
      n1    = NUM_W'(m02) + NUM_W'(m20);
      n2    = NUM_W'(m12) + NUM_W'(m21);
    end else if (m11 > m00) begin
      dom   = DOM_Y;
      rad_s = (DW+3)'(m11) - (DW+3)'(m22) - (DW+3)'(m00) + one_s;
      n0    = NUM_W'(m02) - NUM_W'(m20);
      n1    = NUM_W'(m21) + NUM_W'(m12);
      n2    = NUM_W'(m01) + NUM_W'(m10);
    end else begin
      dom   = DOM_X;
      rad_s = (DW+3)'(m00) - (DW+3)'(m11) - (DW+3)'(m22) + one_s;
      n0    = NUM_W'(m21) - NUM_W'(m12);
      n1    = NUM_W'(m10) + NUM_W'(m01);
      n2    = NUM_W'(m20) + NUM_W'(m02);
    end
    rad = (rad_s < 0) ? '0 : rad_s[RAD_W-1:0];
    out_d_nxt.x    = X_W'({rad, {FRAC_BITS{1'b0}}});
    out_d_nxt.rem  = '0;
    out_d_nxt.root = '0;
    out_d_nxt.num  = {n2, n1, n0};
    out_d_nxt.dom  = dom;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_v = out_v_r;
  assign out_d = out_d_r;
endmodule

// File: rtl/rmq_sqrt_stage.sv
// ----------------------------------------------------------------------------
// Square root stage
// Two digit-by-digit integer square root steps, then a register.
// ----------------------------------------------------------------------------
module rmq_sqrt_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_v,
  input  rmq_pkg::sq_t in_d,
  output logic         out_v,
  output rmq_pkg::sq_t out_d
);
  import rmq_pkg::*;

  logic out_v_r;
  sq_t  out_d_r, mid, out_d_nxt;

  function automatic sq_t sq_step(sq_t s);
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] trial;
    sq_t              o;
    o     = s;
    r2    = {s.rem, s.x[X_W-1 -: 2]};
    trial = (REM_W+2)'({s.root, 2'b01});
    if (r2 >= trial) begin
      o.rem  = REM_W'(r2 - trial);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r2[REM_W-1:0];
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    o.x = s.x << 2;
    return o;
  endfunction

  always_comb begin
    mid       = sq_step(in_d);
    out_d_nxt = sq_step(mid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_v = out_v_r;
  assign out_d = out_d_r;
endmodule

// File: rtl/rmq_div_setup.sv
// ----------------------------------------------------------------------------
// Divider setup stage
// Forms dividend, divisor and overflow flag for each lane from the root, plus the dominant value and degenerate flag.
// ----------------------------------------------------------------------------
module rmq_div_setup (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_v,
  input  rmq_pkg::sq_t in_d,
  output logic         out_v,
  output rmq_pkg::dv_t out_d
);
  import rmq_pkg::*;

  logic             out_v_r;
  dv_t              out_d_r, out_d_nxt;
  logic [ROOT_W:0]  r_inc;
  logic [DSH_W-1:0] dsh0;

  always_comb begin
    logic [NUM_W-1:0] absn;
    logic [N_W-1:0]   nn;
    r_inc = {1'b0, in_d.root} + (ROOT_W+1)'(1);
    // Divisor is twice the root, aligned to the top quotient bit.
    dsh0  = DSH_W'({in_d.root, 1'b0, {(Q_W-1){1'b0}}});
    out_d_nxt.dom_val = r_inc[ROOT_W:1];
    out_d_nxt.dom     = in_d.dom;
    out_d_nxt.degen   = (in_d.root == '0);
    for (int l = 0; l < LANES; l++) begin
      out_d_nxt.lane[l].neg = in_d.num[l][NUM_W-1];
      absn = in_d.num[l][NUM_W-1] ? (~in_d.num[l] + NUM_W'(1)) : in_d.num[l];
      nn   = N_W'({absn, {FRAC_BITS{1'b0}}}) + N_W'(in_d.root);
      out_d_nxt.lane[l].rem = nn;
      out_d_nxt.lane[l].dsh = dsh0;
      out_d_nxt.lane[l].q   = '0;
      out_d_nxt.lane[l].ovf = (DSH_W'(nn) >= dsh0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_v = out_v_r;
  assign out_d = out_d_r;
endmodule

// File: rtl/rmq_div_stage.sv
// ----------------------------------------------------------------------------
// Divider stage
// Two restoring division steps on each of the three lanes, then a register.
// ----------------------------------------------------------------------------
module rmq_div_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_v,
  input  rmq_pkg::dv_t in_d,
  output logic         out_v,
  output rmq_pkg::dv_t out_d
);
  import rmq_pkg::*;

  logic out_v_r;
  dv_t  out_d_r, out_d_nxt;

  function automatic lane_t div_step(lane_t s);
    lane_t o;
    o = s;
    if (DSH_W'(s.rem) >= s.dsh) begin
      o.rem = s.rem - s.dsh[N_W-1:0];
      o.q   = {s.q[Q_W-2:0], 1'b1};
    end else begin
      o.q   = {s.q[Q_W-2:0], 1'b0};
    end
    o.dsh = s.dsh >> 1;
    return o;
  endfunction

  always_comb begin
    out_d_nxt = in_d;
    for (int l = 0; l < LANES; l++) begin
      out_d_nxt.lane[l] = div_step(div_step(in_d.lane[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_v = out_v_r;
  assign out_d = out_d_r;
endmodule

// File: rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Pipelined Shoemake conversion of a Q2.14 3x3 matrix to a Q2.14 quaternion.
//
// Channel  Direction  Payload
// in_      slave      nine matrix elements m00..m22, 16 bits each
// out_     master     qw, qx, qy, qz in tdata; degenerate in tuser
//
// One transaction per cycle sustained while out_tready is high; the registered stages in order are the front stage,
// eight square root stages, divider setup, eight divider stages and the output.
// Reset clears only the valid bits of the stages.
// A stall on the output freezes the whole pipeline; in_tready follows it.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
  input  logic [rmq_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // qw, qx, qy, qz from bit 0 up
  output logic [rmq_pkg::OUT_W-1:0] out_tdata,
  // degenerate
  output logic [0:0]                out_tuser
);
  import rmq_pkg::*;

  logic                en;
  logic                sq_v [0:SQ_STAGES];
  sq_t                 sq_d [0:SQ_STAGES];
  logic                dv_v [0:DIV_STAGES];
  dv_t                 dv_d [0:DIV_STAGES];
  logic                out_tvalid_r;
  logic [OUT_W-1:0]    out_tdata_r, out_tdata_nxt;
  logic                out_tuser_r;
  logic [LANES-1:0][DW-1:0] lv;
  logic [DW-1:0]       dv;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  rmq_prep u_prep (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(in_tvalid), .in_d(in_tdata),
    .out_v(sq_v[0]), .out_d(sq_d[0])
  );

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sq
    rmq_sqrt_stage u_sq (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_v(sq_v[s]), .in_d(sq_d[s]),
      .out_v(sq_v[s+1]), .out_d(sq_d[s+1])
    );
  end

  rmq_div_setup u_setup (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(sq_v[SQ_STAGES]), .in_d(sq_d[SQ_STAGES]),
    .out_v(dv_v[0]), .out_d(dv_d[0])
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    rmq_div_stage u_div (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_v(dv_v[s]), .in_d(dv_d[s]),
      .out_v(dv_v[s+1]), .out_d(dv_d[s+1])
    );
  end

  always_comb begin
    dv_t f;
    f = dv_d[DIV_STAGES];
    for (int l = 0; l < LANES; l++) begin
      if (f.degen) begin
        lv[l] = '0;
      end else if (f.lane[l].ovf) begin
        lv[l] = f.lane[l].neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        lv[l] = f.lane[l].neg ? (~f.lane[l].q + DW'(1)) : f.lane[l].q;
      end
    end
    dv = f.degen ? '0 : f.dom_val;
    unique case (f.dom)
      DOM_W:   out_tdata_nxt = {lv[2], lv[1], lv[0], dv};
      DOM_X:   out_tdata_nxt = {lv[2], lv[1], dv, lv[0]};
      DOM_Y:   out_tdata_nxt = {lv[1], dv, lv[2], lv[0]};
      DOM_Z:   out_tdata_nxt = {dv, lv[2], lv[1], lv[0]};
      default: out_tdata_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dv_v[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= dv_d[DIV_STAGES].degen;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

  // A degenerate result carries an all-zero quaternion.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("degenerate result with nonzero components");

  // A regular result always has a nonzero dominant component.
  a_regular_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata != '0)
    else $error("regular result with all-zero components");

  // While the output is stalled, the input side is closed.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted during output stall");
endmodule
